// ===== rtl/core/nbtm_pkg.sv =====
// Shared constants, types and state encoding for the N-bonacci matrix-power block.
`timescale 1ns / 1ps
package nbtm_pkg;

    // Width of one matrix entry and of the result.
    localparam int VALUE_W = 30;
    // Width of the order register.
    localparam int ORDER_W = 4;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;

    // The prime modulus, at entry width and at the width of the reduction unit.
    localparam logic [VALUE_W-1:0] PRIME_MOD = 30'd1000000009;
    localparam logic [31:0] PRIME_W32 = 32'd1000000009;

    // Barrett constant floor(2^60 / p), which fits in 31 bits.
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000009);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PSTEP,
        ST_SHIFT,
        ST_MUL,
        ST_DRAIN,
        ST_COPY,
        ST_COPYW,
        ST_SUM,
        ST_SUMEND
    } nbtm_state_t;

endpackage

// ===== rtl/core/nbtm_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module nbtm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
    input  logic [WIDTH-1:0]                      wd,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra_a,
    output logic [WIDTH-1:0]                      rd_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra_b,
    output logic [WIDTH-1:0]                      rd_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a <= mem[ra_a];
        rd_b <= mem[ra_b];
    end

endmodule

// ===== rtl/core/nbonacci_term_matrix_power.sv =====
// Top level: N-bonacci term modulo 1000000009 by companion-matrix power.
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+--------------------------------
//  request   | start, term_index                     | taken when start && !busy
//  result    | done, term_value                      | one-cycle strobe, no back-pressure
//  config    | cfg_valid, cfg_ready, cfg_data(order) | written when cfg_valid && cfg_ready
//
// An index M <= N answers in the cycle after the request. Otherwise the block
// sweeps the N*N entries to load the matrices, then runs up to 2*floor(log2(M-N))+1
// matrix products, each issuing N^3 multiply-accumulates through the one shared modular
// multiply pipeline, which is drained before the product is copied back; the last row
// is then summed. The run time is set by the single multiply-accumulate path.
// Reset is asynchronous and clears control state only; no clearing pass.
`timescale 1ns / 1ps
module nbonacci_term_matrix_power #(
    parameter int MAX_ORDER  = 8,
    parameter int INDEX_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [INDEX_BITS-1:0]         term_index,
    output logic                          done,
    output logic [nbtm_pkg::VALUE_W-1:0]  term_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nbtm_pkg::ORDER_W-1:0]  cfg_data
);

    import nbtm_pkg::*;

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW = $clog2(MAX_ORDER + 1);

    // Tag that travels with each multiply-accumulate through the pipeline.
    typedef struct packed {
        logic          v;
        logic          first;
        logic          last;
        logic [AW-1:0] waddr;
    } mac_tag_t;

    nbtm_state_t state_reg, state_next;
    logic [ORDER_W-1:0]    order_reg;
    logic [INDEX_BITS-1:0] e_reg, e_next;
    logic [CW-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                  op_reg, op_next;
    logic                  done_reg, done_next;
    logic [VALUE_W-1:0]    term_value_reg, term_value_next;

    logic [NW-1:0]         n_eff;
    logic [CW-1:0]         nm1;
    logic [INDEX_BITS-1:0] n_ext;
    logic                  ij_last, j_last, k_last;

    logic issue_mul, init_we, cp_issue, sum_issue;

    logic [AW-1:0] addr_ij, addr_ik, addr_kj, addr_sum;

    // Memory ports.
    logic               p_we, b_we, s_we;
    logic [AW-1:0]      p_wa, b_wa, s_wa, p_ra;
    logic [VALUE_W-1:0] p_wd, b_wd, s_wd;
    logic [VALUE_W-1:0] p_qa, b_qa, b_qb, s_qa;
    logic [VALUE_W-1:0] init_p_val, init_b_val;

    // Multiply pipeline.
    mac_tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, tag_issue;
    logic [59:0]        prod_reg;
    logic [30:0]        q_reg;
    logic [31:0]        xlo3_reg, xlo4_reg, qp_reg;
    logic [30:0]        r1_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] a_op;
    logic [61:0]        q_full;
    logic [60:0]        qp_full;
    logic [31:0]        r0, r0_red;
    logic [VALUE_W:0]   r1_sub;
    logic [VALUE_W-1:0] r2;
    logic [VALUE_W:0]   acc_sum, acc_red;
    logic [VALUE_W-1:0] acc_base;
    logic               pipe_busy;

    // Copy and row-sum pipelines.
    logic               cp_v_reg;
    logic [AW-1:0]      cp_addr_reg;
    logic               sum_v_reg, sum_first_reg;
    logic [VALUE_W-1:0] sum_acc_reg, sum_base;
    logic [VALUE_W:0]   sum_s, sum_red;

    // Effective order: zero counts as one, values above the maximum saturate.
    always_comb
    begin
        if (order_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if ({1'b0, order_reg} > (ORDER_W + 1)'(MAX_ORDER))
        begin
            n_eff = NW'(MAX_ORDER);
        end
        else
        begin
            n_eff = NW'(order_reg);
        end
    end

    assign nm1   = CW'(n_eff - 1'b1);
    assign n_ext = INDEX_BITS'(n_eff);

    // Row-major addresses with a fixed stride of MAX_ORDER.
    assign addr_ij  = AW'(int'(i_reg) * MAX_ORDER + int'(j_reg));
    assign addr_ik  = AW'(int'(i_reg) * MAX_ORDER + int'(k_reg));
    assign addr_kj  = AW'(int'(k_reg) * MAX_ORDER + int'(j_reg));
    assign addr_sum = AW'(int'(nm1) * MAX_ORDER + int'(j_reg));

    assign j_last  = (j_reg == nm1);
    assign k_last  = (k_reg == nm1);
    assign ij_last = (i_reg == nm1) && j_last;

    // Identity for the power, companion matrix for the base.
    assign init_p_val = (i_reg == j_reg) ? VALUE_W'(1) : '0;
    assign init_b_val = ((CW + 1)'(j_reg) == (CW + 1)'(i_reg) + 1'b1 || i_reg == nm1)
                      ? VALUE_W'(1) : '0;

    // Sequencer: next state, counters and strobes.
    always_comb
    begin
        state_next      = state_reg;
        e_next          = e_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        op_next         = op_reg;
        done_next       = 1'b0;
        term_value_next = term_value_reg;
        issue_mul       = 1'b0;
        init_we         = 1'b0;
        cp_issue        = 1'b0;
        sum_issue       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (term_index <= n_ext)
                    begin
                        term_value_next = VALUE_W'(1);
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        e_next     = term_index - n_ext;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                init_we = 1'b1;
                if (j_last)
                begin
                    j_next = '0;
                    i_next = CW'(i_reg + 1'b1);
                end
                else
                begin
                    j_next = CW'(j_reg + 1'b1);
                end
                if (ij_last)
                begin
                    state_next = ST_PSTEP;
                end
            end
            ST_PSTEP:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (e_reg[0])
                begin
                    op_next    = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                e_next = e_reg >> 1;
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if ((e_reg >> 1) != '0)
                begin
                    op_next    = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_MUL:
            begin
                issue_mul = 1'b1;
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = CW'(i_reg + 1'b1);
                    end
                    else
                    begin
                        j_next = CW'(j_reg + 1'b1);
                    end
                end
                else
                begin
                    k_next = CW'(k_reg + 1'b1);
                end
                if (ij_last && k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                i_next = '0;
                j_next = '0;
                if (!pipe_busy)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cp_issue = 1'b1;
                if (j_last)
                begin
                    j_next = '0;
                    i_next = CW'(i_reg + 1'b1);
                end
                else
                begin
                    j_next = CW'(j_reg + 1'b1);
                end
                if (ij_last)
                begin
                    state_next = ST_COPYW;
                end
            end
            ST_COPYW:
            begin
                state_next = op_reg ? ST_PSTEP : ST_SHIFT;
            end
            ST_SUM:
            begin
                sum_issue = 1'b1;
                j_next    = CW'(j_reg + 1'b1);
                if (j_last)
                begin
                    state_next = ST_SUMEND;
                end
            end
            ST_SUMEND:
            begin
                term_value_next = sum_red[VALUE_W-1:0];
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            order_reg <= ORDER_RESET;
            e_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            op_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        term_value_reg <= term_value_next;
    end

    // Memory port selection.
    assign p_ra = sum_issue ? addr_sum : addr_ik;
    assign p_we = init_we || (cp_v_reg && !op_reg);
    assign p_wa = init_we ? addr_ij : cp_addr_reg;
    assign p_wd = init_we ? init_p_val : s_qa;
    assign b_we = init_we || (cp_v_reg && op_reg);
    assign b_wa = init_we ? addr_ij : cp_addr_reg;
    assign b_wd = init_we ? init_b_val : s_qa;

    nbtm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_power_ram (
        .clk  (clk),
        .we   (p_we),
        .wa   (p_wa),
        .wd   (p_wd),
        .ra_a (p_ra),
        .rd_a (p_qa),
        .ra_b (addr_kj),
        .rd_b ()
    );

    nbtm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_base_ram (
        .clk  (clk),
        .we   (b_we),
        .wa   (b_wa),
        .wd   (b_wd),
        .ra_a (addr_ik),
        .rd_a (b_qa),
        .ra_b (addr_kj),
        .rd_b (b_qb)
    );

    nbtm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_scratch_ram (
        .clk  (clk),
        .we   (s_we),
        .wa   (s_wa),
        .wd   (s_wd),
        .ra_a (addr_ij),
        .rd_a (s_qa),
        .ra_b (addr_ij),
        .rd_b ()
    );

    // Tag for the element being issued.
    always_comb
    begin
        tag_issue.v     = issue_mul;
        tag_issue.first = (k_reg == '0);
        tag_issue.last  = k_last;
        tag_issue.waddr = addr_ij;
    end

    assign pipe_busy = t1_reg.v || t2_reg.v || t3_reg.v || t4_reg.v || t5_reg.v;

    // Barrett reduction arithmetic, one stage per register.
    assign a_op    = op_reg ? b_qa : p_qa;
    assign q_full  = 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
    assign qp_full = 61'(q_reg) * 61'(PRIME_MOD);
    assign r0      = xlo4_reg - qp_reg;
    assign r0_red  = (r0 >= PRIME_W32) ? (r0 - PRIME_W32) : r0;
    assign r1_sub  = (r1_reg >= 31'(PRIME_MOD)) ? (r1_reg - 31'(PRIME_MOD)) : r1_reg;
    assign r2      = r1_sub[VALUE_W-1:0];
    assign acc_base = t5_reg.first ? '0 : acc_reg;
    assign acc_sum  = {1'b0, acc_base} + {1'b0, r2};
    assign acc_red  = (acc_sum >= {1'b0, PRIME_MOD}) ? (acc_sum - {1'b0, PRIME_MOD}) : acc_sum;

    // A finished dot product goes to the scratch matrix.
    assign s_we = t5_reg.v && t5_reg.last;
    assign s_wa = t5_reg.waddr;
    assign s_wd = acc_red[VALUE_W-1:0];

    // Pipeline tags and the copy and sum valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg    <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            t4_reg    <= '0;
            t5_reg    <= '0;
            cp_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end
        else
        begin
            t1_reg    <= tag_issue;
            t2_reg    <= t1_reg;
            t3_reg    <= t2_reg;
            t4_reg    <= t3_reg;
            t5_reg    <= t4_reg;
            cp_v_reg  <= cp_issue;
            sum_v_reg <= sum_issue;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        prod_reg      <= {30'b0, a_op} * {30'b0, b_qb};
        q_reg         <= q_full[61:31];
        xlo3_reg      <= prod_reg[31:0];
        qp_reg        <= qp_full[31:0];
        xlo4_reg      <= xlo3_reg;
        r1_reg        <= r0_red[30:0];
        cp_addr_reg   <= addr_ij;
        sum_first_reg <= (j_reg == '0);
        if (t5_reg.v)
        begin
            acc_reg <= acc_red[VALUE_W-1:0];
        end
        if (sum_v_reg)
        begin
            sum_acc_reg <= sum_red[VALUE_W-1:0];
        end
    end

    // Row sum of the final power.
    assign sum_base = sum_first_reg ? '0 : sum_acc_reg;
    assign sum_s    = {1'b0, sum_base} + {1'b0, p_qa};
    assign sum_red  = (sum_s >= {1'b0, PRIME_MOD}) ? (sum_s - {1'b0, PRIME_MOD}) : sum_s;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign term_value = term_value_reg;
    assign cfg_ready  = 1'b1;

endmodule

// ===== rtl/core/nbtm_checker.sv =====
// Port-level checker for the N-bonacci matrix-power block, with its bind.
`timescale 1ns / 1ps
module nbtm_checker #(
    parameter int INDEX_BITS = 31
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [INDEX_BITS-1:0]        term_index,
    input logic                         done,
    input logic [nbtm_pkg::VALUE_W-1:0] term_value
);

    import nbtm_pkg::*;

    // An accepted request either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request neither answered nor in progress");

    // Whenever the block leaves its busy period, it shows a result in that cycle.
    a_fall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Entering a long computation never coincides with a result.
    a_rise_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !done)
        else $error("result shown as a long computation starts");

    // Results are reduced below the prime.
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (term_value < PRIME_MOD))
        else $error("result not reduced");

    // The first term is always one.
    a_first_term: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && term_index == INDEX_BITS'(1)) |=> (done && term_value == 30'd1))
        else $error("first term is not one");

endmodule

bind nbonacci_term_matrix_power nbtm_checker #(.INDEX_BITS(INDEX_BITS)) u_nbtm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .term_index (term_index),
    .done       (done),
    .term_value (term_value)
);

// ===== tb/tb_top.sv =====
// Testbench for the N-bonacci matrix-power block: directed and random requests, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
    import nbtm_pkg::*;

    localparam logic [63:0] PRIME = 64'd1000000009;
    localparam int MAXN = 8;
    localparam int WATCHDOG = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [30:0]          term_index;
    logic                 done;
    logic [VALUE_W-1:0]   term_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ORDER_W-1:0]   cfg_data;

    nbonacci_term_matrix_power u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .term_index(term_index), .done(done), .term_value(term_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Pending requests and expected term values.
    logic [30:0]        pending_index[$];
    logic [VALUE_W-1:0] expected_terms[$];
    logic [ORDER_W-1:0] model_order;
    int                 send_gap_pct;
    bit                 feed_enable;
    int                 mismatches;
    int                 idle_cycles;
    int                 requests_sent;
    int                 results_seen;
    int                 order_settings;

    typedef logic [63:0] sq_matrix_t [MAXN][MAXN];

    // Product of two n-by-n matrices modulo the prime.
    function automatic sq_matrix_t mat_product(sq_matrix_t a, sq_matrix_t b, int n);
        sq_matrix_t r;
        logic [63:0] acc;
        for (int i = 0; i < MAXN; i++)
            for (int j = 0; j < MAXN; j++)
                r[i][j] = 0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc = (acc + (a[i][k] * b[k][j]) % PRIME) % PRIME;
                r[i][j] = acc;
            end
        end
        return r;
    endfunction

    // Term M of the order-N sequence modulo the prime.
    function automatic logic [VALUE_W-1:0] nbonacci_term(logic [30:0] m,
                                                         logic [ORDER_W-1:0] ord);
        int n;
        logic [63:0] e;
        logic [63:0] sum;
        sq_matrix_t pw;
        sq_matrix_t bs;
        n = ord;
        if (n < 1) n = 1;
        if (n > MAXN) n = MAXN;
        if (m <= n) return 1;
        for (int i = 0; i < MAXN; i++)
            for (int j = 0; j < MAXN; j++)
            begin
                pw[i][j] = (i == j) ? 1 : 0;
                bs[i][j] = ((j == i + 1) || (i == n - 1)) ? 1 : 0;
            end
        e = m - n;
        while (e != 0)
        begin
            if (e[0]) pw = mat_product(pw, bs, n);
            e = e >> 1;
            if (e != 0) bs = mat_product(bs, bs, n);
        end
        sum = 0;
        for (int i = 0; i < n; i++)
            sum = (sum + pw[n-1][i]) % PRIME;
        return sum[VALUE_W-1:0];
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Request driver: takes indexes from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            term_index <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_terms.push_back(nbonacci_term(term_index, model_order));
                requests_sent++;
            end
            if (feed_enable && pending_index.size() > 0 &&
                $urandom_range(99, 0) >= send_gap_pct)
            begin
                start      <= 1'b1;
                term_index <= pending_index.pop_front();
            end
            else
            begin
                start      <= 1'b0;
                term_index <= 31'($urandom);
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_terms.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result term_value=%0d", term_value);
            end
            else
            begin
                logic [VALUE_W-1:0] want;
                want = expected_terms.pop_front();
                if (want !== term_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("term_value mismatch: expected %0d, got %0d",
                                 want, term_value);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request, result or config write.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("[nbonacci_term_matrix_power] ERROR");
            $finish;
        end
    end

    // Write the order register while the block is idle.
    task automatic write_order(input logic [ORDER_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model_order = value;
        order_settings++;
    endtask

    // Wait until every queued request has been sent and answered.
    task automatic drain_all();
        while (pending_index.size() > 0 || start || expected_terms.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random index: mostly small, some near the order, a few full width.
    function automatic logic [30:0] pick_index();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 3) return 31'($urandom_range(10, 0));
        if (sel < 7) return 31'($urandom_range(1000, 0));
        if (sel < 9) return 31'($urandom_range(1 << 20, 0));
        return 31'($urandom);
    endfunction

    task automatic run_phase(input logic [ORDER_W-1:0] ord, input int count,
                             input int gap);
        write_order(ord);
        send_gap_pct = gap;
        for (int i = 0; i < count; i++)
            pending_index.push_back(pick_index());
        drain_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        feed_enable = 1'b0;
        send_gap_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        requests_sent = 0;
        results_seen = 0;
        order_settings = 0;
        model_order = ORDER_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        feed_enable = 1'b1;

        // Directed: reset order, then extremes of index and order.
        pending_index.push_back(31'd0);
        pending_index.push_back(31'd1);
        pending_index.push_back(31'd2);
        pending_index.push_back(31'd3);
        pending_index.push_back(31'd10);
        drain_all();
        write_order(4'd0);
        pending_index.push_back(31'd1);
        pending_index.push_back(31'd5);
        drain_all();
        write_order(4'd8);
        pending_index.push_back(31'd8);
        pending_index.push_back(31'd9);
        pending_index.push_back(31'h7FFF_FFFF);
        pending_index.push_back(31'h5555_5555);
        drain_all();
        write_order(4'd15);
        pending_index.push_back(31'd20);
        pending_index.push_back(31'h2AAA_AAAA);
        drain_all();
        write_order(4'd1);
        pending_index.push_back(31'd2);
        pending_index.push_back(31'h7FFF_FFFF);
        drain_all();

        // Random: sender idles rarely, then often, then never.
        run_phase(4'($urandom_range(8, 1)), 30, 7);
        run_phase(4'($urandom_range(15, 0)), 30, 85);
        run_phase(4'($urandom_range(4, 2)), 40, 0);

        drain_all();
        $display("Sent %0d requests over %0d order settings, %0d results checked.",
                 requests_sent, order_settings, results_seen);
        if (mismatches == 0 && expected_terms.size() == 0)
            $display("[nbonacci_term_matrix_power] OK");
        else
            $display("[nbonacci_term_matrix_power] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/nbtm_pkg.sv
rtl/core/nbtm_ram.sv
rtl/core/nbonacci_term_matrix_power.sv
rtl/core/nbtm_checker.sv
tb/tb_top.sv
